FILE: rtl/core/bos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bos_pkg;

	// Default sizes: coordinates in pixels, ratios with this many fraction bits.
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	// The four ratio dividers, which run side by side; these are their indices.
	localparam int NUM_RATIOS = 4;
	localparam int RAT_IOU    = 0;
	localparam int RAT_PREC   = 1;
	localparam int RAT_REC    = 2;
	localparam int RAT_F      = 3;

endpackage

`default_nettype wire

FILE: rtl/core/box_overlap_scorer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------------
// input    | in_valid / in_stall   | det_* and gt_* box corners and extents
// output   | out_valid / out_stall | overlap_area, four ratios, boxes_overlap
//
// One item enters every cycle while in_stall is low and passes through three stages
// of box geometry, area products and divider setup, FRAC_BITS + 1 restoring divider
// stages (one quotient bit each, four dividers side by side), and the output register.
// Reset clears only the valid bits of the stages. A stall on the output holds the
// last stage, and the hold moves back only as far as the stages are full, so empty
// slots close up and the input takes items while a result waits, until none is empty.

module box_overlap_scorer import bos_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,

	input  wire logic                    in_valid,
	output      logic                    in_stall,
	input  wire logic [COORD_BITS-1:0]   det_first_column,
	input  wire logic [COORD_BITS-1:0]   det_first_line,
	input  wire logic [COORD_BITS:0]     det_width,
	input  wire logic [COORD_BITS:0]     det_height,
	input  wire logic [COORD_BITS-1:0]   gt_first_column,
	input  wire logic [COORD_BITS-1:0]   gt_first_line,
	input  wire logic [COORD_BITS:0]     gt_width,
	input  wire logic [COORD_BITS:0]     gt_height,

	output      logic                    out_valid,
	input  wire logic                    out_stall,
	output      logic [2*COORD_BITS:0]   overlap_area,
	output      logic [FRAC_BITS:0]      iou_ratio,
	output      logic [FRAC_BITS:0]      precision_ratio,
	output      logic [FRAC_BITS:0]      recall_ratio,
	output      logic [FRAC_BITS:0]      f_ratio,
	output      logic                    boxes_overlap
);

	// Extent width, area width, divider operand width, quotient bits, remainder width.
	localparam int SW = COORD_BITS + 1;
	localparam int AW = 2 * COORD_BITS + 1;
	localparam int DW = AW + 1;
	localparam int Q  = FRAC_BITS + 1;
	localparam int RW = DW + 1;
	localparam int EW = COORD_BITS + 3;
	// Stages: box geometry, products, divider setup plus Q divider steps, output.
	localparam int NSTG = Q + 4;

	localparam logic [SW-1:0] SIZE_MAX = SW'(1) << COORD_BITS;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [DW-1:0] den;
		logic [Q-1:0]  quo;
	} div_t;

	typedef struct packed {
		div_t [NUM_RATIOS-1:0] dv;
		logic [AW-1:0]         area;
		logic                  ov;
	} item_t;

	function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] w);
		return (w > SIZE_MAX) ? SIZE_MAX : w;
	endfunction

	function automatic logic signed [EW-1:0] last_of(input logic [COORD_BITS-1:0] c,
			input logic [SW-1:0] w);
		return $signed({3'b000, c}) + $signed({2'b00, w}) - EW'(1);
	endfunction

	function automatic logic [SW-1:0] span(input logic signed [EW-1:0] a0,
			input logic signed [EW-1:0] a1, input logic signed [EW-1:0] b0,
			input logic signed [EW-1:0] b1);
		logic signed [EW-1:0] lo;
		logic signed [EW-1:0] hi;
		logic signed [EW-1:0] n;
		lo = (a0 > b0) ? a0 : b0;
		hi = (a1 < b1) ? a1 : b1;
		n  = hi - lo + EW'(1);
		// A negative or zero extent means the boxes do not meet on this axis.
		return (!n[EW-1] && n != '0) ? n[SW-1:0] : '0;
	endfunction

	// Boxes are apart on an axis when one starts and also ends before the other starts.
	function automatic logic meets(input logic signed [EW-1:0] a0,
			input logic signed [EW-1:0] a1, input logic signed [EW-1:0] b0,
			input logic signed [EW-1:0] b1);
		return !((a0 < b0 && a1 < b0) || (b0 < a0 && b1 < a0));
	endfunction

	// One restoring step: settle one quotient bit and shift the remainder up.
	function automatic div_t div_step(input div_t d);
		div_t r;
		logic take;
		r    = d;
		take = (d.rem >= RW'(d.den));
		if (take) begin
			r.rem = d.rem - RW'(d.den);
		end
		r.rem = r.rem << 1;
		r.quo = {d.quo[Q-2:0], take};
		return r;
	endfunction

	// Stage valid bits and per-stage advance.
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: clamp extents, intersection extents, overlap test.
	logic [SW-1:0] iw_s1, ih_s1, dw_s1, dh_s1, gw_s1, gh_s1;
	logic          ov_s1;

	always_ff @(posedge clk) begin
		logic [SW-1:0]        dw, dh, gw, gh;
		logic signed [EW-1:0] dc0, dc1, dl0, dl1, gc0, gc1, gl0, gl1;
		dw  = clamp_size(det_width);
		dh  = clamp_size(det_height);
		gw  = clamp_size(gt_width);
		gh  = clamp_size(gt_height);
		dc0 = $signed({3'b000, det_first_column});
		dl0 = $signed({3'b000, det_first_line});
		gc0 = $signed({3'b000, gt_first_column});
		gl0 = $signed({3'b000, gt_first_line});
		dc1 = last_of(det_first_column, dw);
		dl1 = last_of(det_first_line, dh);
		gc1 = last_of(gt_first_column, gw);
		gl1 = last_of(gt_first_line, gh);
		if (adv[0]) begin
			iw_s1 <= span(dc0, dc1, gc0, gc1);
			ih_s1 <= span(dl0, dl1, gl0, gl1);
			dw_s1 <= dw;
			dh_s1 <= dh;
			gw_s1 <= gw;
			gh_s1 <= gh;
			ov_s1 <= meets(dc0, dc1, gc0, gc1) && meets(dl0, dl1, gl0, gl1);
		end
	end

	// Stage 2: the three areas.
	logic [AW-1:0] inter_s2, da_s2, ga_s2;
	logic          ov_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			inter_s2 <= AW'(iw_s1 * ih_s1);
			da_s2    <= AW'(dw_s1 * dh_s1);
			ga_s2    <= AW'(gw_s1 * gh_s1);
			ov_s2    <= ov_s1;
		end
	end

	// Divider setup and steps. Every numerator is at most its denominator, so the
	// quotient fits Q bits and the first step can start from the plain numerator.
	// The F-measure divider gets a zero denominator when the boxes do not overlap.
	item_t dv_s [0:Q];

	always_ff @(posedge clk) begin
		logic [DW-1:0] sum;
		sum = DW'(da_s2) + DW'(ga_s2);
		if (adv[2]) begin
			dv_s[0].area <= inter_s2;
			dv_s[0].ov   <= ov_s2;
			dv_s[0].dv[RAT_IOU]  <= '{rem: RW'(inter_s2), den: sum - DW'(inter_s2), quo: '0};
			dv_s[0].dv[RAT_PREC] <= '{rem: RW'(inter_s2), den: DW'(da_s2), quo: '0};
			dv_s[0].dv[RAT_REC]  <= '{rem: RW'(inter_s2), den: DW'(ga_s2), quo: '0};
			dv_s[0].dv[RAT_F]    <= '{rem: RW'({inter_s2, 1'b0}),
				den: ov_s2 ? sum : '0, quo: '0};
		end
	end

	for (genvar g = 1; g <= Q; g++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[g+2]) begin
				dv_s[g].area <= dv_s[g-1].area;
				dv_s[g].ov   <= dv_s[g-1].ov;
				for (int r = 0; r < NUM_RATIOS; r++) begin
					dv_s[g].dv[r] <= div_step(dv_s[g-1].dv[r]);
				end
			end
		end
	end

	// Output register; a zero denominator gives a zero ratio.
	function automatic logic [Q-1:0] ratio_of(input div_t d);
		return (d.den != '0) ? d.quo : '0;
	endfunction

	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) begin
			overlap_area    <= dv_s[Q].area;
			iou_ratio       <= ratio_of(dv_s[Q].dv[RAT_IOU]);
			precision_ratio <= ratio_of(dv_s[Q].dv[RAT_PREC]);
			recall_ratio    <= ratio_of(dv_s[Q].dv[RAT_REC]);
			f_ratio         <= ratio_of(dv_s[Q].dv[RAT_F]);
			boxes_overlap   <= dv_s[Q].ov;
		end
	end

	// The input is held back only when the whole pipe is full behind a stall.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_q == '1 && out_stall))
		else $error("input held while the pipeline has room");

	// Boxes that do not overlap score no F-measure.
	a_f_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !boxes_overlap) |-> (f_ratio == '0))
		else $error("F-measure set for boxes that do not overlap");

	// An empty intersection gives zero IoU, precision and recall.
	a_no_area: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overlap_area == '0) |->
		(iou_ratio == '0 && precision_ratio == '0 && recall_ratio == '0))
		else $error("ratio set with empty intersection");

	// Neither the IoU nor the F-measure ratio exceeds one.
	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iou_ratio <= (Q'(1) << FRAC_BITS) &&
		f_ratio <= (Q'(1) << FRAC_BITS)))
		else $error("ratio above one");

endmodule

`default_nettype wire
